// ===== rtl/eass_pkg.sv =====
`timescale 1ns / 1ps
// Package for the energy-aware sleep scheduler.
// Holds register indexes, reset values, band codes and divide constants.
package eass_pkg;

	localparam int unsigned DataW = 16;
	localparam int unsigned CfgIdxW = 3;

	typedef logic [DataW-1:0] word_t;

	localparam logic [CfgIdxW-1:0] REG_FASTEST  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SLOWEST  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LOWV     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SHUTOFF  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CEILING  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TARGET   = 3'd5;

	localparam word_t RST_FASTEST = 16'd1;
	localparam word_t RST_SLOWEST = 16'd7200;
	localparam word_t RST_LOWV    = 16'd7200;
	localparam word_t RST_SHUTOFF = 16'd3000;
	localparam word_t RST_CEILING = 16'd5000;
	localparam word_t RST_TARGET  = 16'd4500;
	localparam word_t RST_PERIOD  = 16'd3600;

	localparam word_t SMALL_STEP  = 16'd10;

	// floor(p/5) = (p*DIV5_MUL) >> 18, floor(p/10) = same >> 19, exact for 16-bit p
	localparam logic [16:0] DIV5_MUL  = 17'd52429;
	localparam int unsigned DIV5_SH   = 18;
	localparam int unsigned DIV10_SH  = 19;
	// floor(p/50) = (p*DIV50_MUL) >> 22, exact for 16-bit p
	localparam logic [16:0] DIV50_MUL = 17'd83887;
	localparam int unsigned DIV50_SH  = 22;

	typedef enum logic [2:0] {
		BAND_SHUTOFF = 3'd0,
		BAND_CEILING = 3'd1,
		BAND_MIAD    = 3'd2,
		BAND_AIMD    = 3'd3,
		BAND_TARGET  = 3'd4
	} band_t;

endpackage

// ===== rtl/energy_aware_sleep_scheduler.sv =====
`timescale 1ns / 1ps
// Energy-aware sleep scheduler: MIAD/AIMD duty-cycle controller, single module.
// Depends on eass_pkg.
//
// Usage:
//   Input channel (voltage_valid / voltage_stall / voltage_mv) takes one averaged
//   capacitor voltage word per wake-up. Output channel (result_valid /
//   result_stall) returns one word per input: sleep_seconds, suspended, band.
//   Config port: cfg_we writes cfg_data into register cfg_index (0..5), no
//   read-back; indexes 6 and 7 are ignored. Write only while the block is idle.
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless a result is stalled. The input register
//   feeds combinational logic (two 16x17 reciprocal multiplies, add, clamp) into
//   the result register, which also updates period and previous-voltage state.
// Stall: while result_stall holds a pending result, the input register keeps
//   its word and voltage_stall rises once that register is full; nothing is
//   dropped.
// Reset (arst_n low): registers return to their defaults, the period to 3600,
//   the previous voltage to 0, and both pipeline registers empty.
module energy_aware_sleep_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                voltage_valid,
	output logic                                voltage_stall,
	input  eass_pkg::word_t                     voltage_mv,
	output logic                                result_valid,
	input  logic                                result_stall,
	output eass_pkg::word_t                     sleep_seconds,
	output logic                                suspended,
	output logic [2:0]                          band,
	input  logic                                cfg_we,
	input  logic [eass_pkg::CfgIdxW-1:0]        cfg_index,
	input  eass_pkg::word_t                     cfg_data
);
	import eass_pkg::*;

	word_t fastest_q, slowest_q, lowv_q, shutoff_q, ceiling_q, target_q;
	word_t period_q, prev_q;

	logic  valid_s1;
	word_t voltage_s1;
	logic  advance;

	word_t        diff;
	logic         neg;
	logic         small_chg;
	logic [32:0]  m5, m50;
	logic [18:0]  p, q5, tenth, q50;
	logic [18:0]  grow_base, grow_step, p_miad, p_aimd, shrink, p_rule, p_clamp;
	word_t        p_next;
	band_t        band_c, band_q;

	function automatic logic [18:0] clamp_period(logic [18:0] x, word_t lo, word_t hi);
		logic [18:0] y;
		y = (x < 19'(lo)) ? 19'(lo) : x;
		y = (y > 19'(hi)) ? 19'(hi) : y;
		return y;
	endfunction

	assign advance       = valid_s1 && (!result_valid || !result_stall);
	assign voltage_stall = valid_s1 && !advance;

	always_comb begin
		diff      = voltage_s1 - prev_q;
		neg       = diff[DataW-1];
		small_chg = !neg && (diff < SMALL_STEP);
		p         = 19'(period_q);
		m5        = 33'(period_q) * 33'(DIV5_MUL);
		m50       = 33'(period_q) * 33'(DIV50_MUL);
		q5        = 19'(m5 >> DIV5_SH);
		tenth     = 19'(m5 >> DIV10_SH);
		q50       = 19'(m50 >> DIV50_SH);

		// MIAD: divide by 5 on non-negative change, then grow by a tenth on a fall or a change below SMALL_STEP
		grow_base = neg ? p : q5;
		grow_step = neg ? tenth : q50;
		if (grow_step == '0) begin
			grow_step = 19'd1;
		end
		p_miad = (neg || small_chg) ? grow_base + grow_step : grow_base;

		// AIMD: shrink by a tenth on a rise, else multiply by 5
		if (tenth == '0) begin
			shrink = (p != '0) ? 19'd1 : 19'd0;
		end else begin
			shrink = tenth;
		end
		p_aimd = (!neg && diff != '0) ? p - shrink : (p << 2) + p;

		p_rule  = (voltage_s1 > target_q) ? p_miad : p_aimd;
		p_clamp = clamp_period(p_rule, fastest_q, slowest_q);

		if (voltage_s1 <= shutoff_q) begin
			band_c = BAND_SHUTOFF;
			p_next = lowv_q;
		end else if (voltage_s1 >= ceiling_q) begin
			band_c = BAND_CEILING;
			p_next = fastest_q;
		end else if (voltage_s1 > target_q) begin
			band_c = BAND_MIAD;
			p_next = p_clamp[DataW-1:0];
		end else if (voltage_s1 < target_q) begin
			band_c = BAND_AIMD;
			p_next = p_clamp[DataW-1:0];
		end else begin
			band_c = BAND_TARGET;
			p_next = period_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fastest_q <= RST_FASTEST;
			slowest_q <= RST_SLOWEST;
			lowv_q    <= RST_LOWV;
			shutoff_q <= RST_SHUTOFF;
			ceiling_q <= RST_CEILING;
			target_q  <= RST_TARGET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FASTEST: fastest_q <= cfg_data;
				REG_SLOWEST: slowest_q <= cfg_data;
				REG_LOWV:    lowv_q    <= cfg_data;
				REG_SHUTOFF: shutoff_q <= cfg_data;
				REG_CEILING: ceiling_q <= cfg_data;
				REG_TARGET:  target_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
			period_q     <= RST_PERIOD;
			prev_q       <= '0;
		end else begin
			if (!voltage_stall) begin
				valid_s1 <= voltage_valid;
			end
			if (advance) begin
				result_valid <= 1'b1;
				period_q     <= p_next;
				prev_q       <= voltage_s1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (voltage_valid && !voltage_stall) begin
			voltage_s1 <= voltage_mv;
		end
		if (advance) begin
			sleep_seconds <= p_next;
			suspended     <= (band_c == BAND_SHUTOFF);
			band_q        <= band_c;
		end
	end

	assign band = band_q;

	a_suspend_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (suspended == (band_q == BAND_SHUTOFF)))
		else $error("suspended flag disagrees with band");

	a_period_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (sleep_seconds == period_q))
		else $error("shown period differs from stored period");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		voltage_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a blocked result");

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (band_q == BAND_MIAD || band_q == BAND_AIMD)
		 && fastest_q <= slowest_q)
		|-> (sleep_seconds >= fastest_q && sleep_seconds <= slowest_q))
		else $error("rule result outside rate limits");

endmodule

// ===== dv/energy_aware_sleep_scheduler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for energy_aware_sleep_scheduler: a queue-fed driver, a result
// monitor checked against an in-bench period predictor, and phases of register settings.
// Depends on eass_pkg and the scheduler RTL.
module energy_aware_sleep_scheduler_tb;
	import eass_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int SETTING_PHASES = 11;
	localparam int WORDS_PER_PHASE = 150;
	localparam int NUM_REGS = 6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		word_t secs;
		logic  susp;
		band_t bnd;
	} sleep_plan_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 voltage_valid = 1'b0;
	logic                 voltage_stall;
	word_t                voltage_mv = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	word_t                sleep_seconds;
	logic                 suspended;
	logic [2:0]           band;
	logic                 cfg_we = 1'b0;
	logic [CfgIdxW-1:0]   cfg_index = '0;
	word_t                cfg_data = '0;

	word_t       reg_copy [NUM_REGS];
	word_t       period_now;
	word_t       last_mv;
	sleep_plan_t awaited_plans [$];
	word_t       volts_to_send [$];
	word_t       gen_last_mv = '0;
	int          sent_cnt = 0;
	int          taken_cnt = 0;
	int          pushed_cnt = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	logic        idle_on = 1'b1;
	logic        long_hold_req = 1'b0;
	logic        long_hold_done = 1'b0;

	energy_aware_sleep_scheduler DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.voltage_valid (voltage_valid),
		.voltage_stall (voltage_stall),
		.voltage_mv    (voltage_mv),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sleep_seconds (sleep_seconds),
		.suspended     (suspended),
		.band          (band),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] bound_period(logic [31:0] p);
		if (p < reg_copy[REG_FASTEST]) p = reg_copy[REG_FASTEST];
		if (p > reg_copy[REG_SLOWEST]) p = reg_copy[REG_SLOWEST];
		return p;
	endfunction

	// next sleep period for one voltage word; advances the period and last-voltage copies
	function automatic sleep_plan_t plan_wake(word_t v);
		word_t       diff;
		logic [31:0] p;
		logic [31:0] tenth;
		sleep_plan_t r;
		diff = v - last_mv;
		p = period_now;
		r.susp = 1'b0;
		if (v <= reg_copy[REG_SHUTOFF]) begin
			r.bnd = BAND_SHUTOFF;
			r.susp = 1'b1;
			p = reg_copy[REG_LOWV];
		end else if (v >= reg_copy[REG_CEILING]) begin
			r.bnd = BAND_CEILING;
			p = reg_copy[REG_FASTEST];
		end else if (v > reg_copy[REG_TARGET]) begin
			r.bnd = BAND_MIAD;
			if (!diff[15]) p = p / 5;
			if (diff[15] || diff < SMALL_STEP) begin
				tenth = p / 10;
				p = p + tenth + (tenth == 0);
			end
			p = bound_period(p);
		end else if (v < reg_copy[REG_TARGET]) begin
			r.bnd = BAND_AIMD;
			if (!diff[15] && diff != 0) begin
				tenth = p / 10;
				if (tenth != 0) p = p - tenth;
				else if (p != 0) p = p - 1;
			end else begin
				p = p * 5;
			end
			p = bound_period(p);
		end else begin
			r.bnd = BAND_TARGET;
		end
		period_now = p[15:0];
		last_mv = v;
		r.secs = p[15:0];
		return r;
	endfunction

	// driver: holds a word until taken, then optional gap, then next word
	always @(negedge clk) begin
		if (!arst_n) begin
			voltage_valid <= 1'b0;
		end else if (voltage_valid && sent_cnt != taken_cnt) begin
			voltage_valid <= 1'b1;
		end else if (gap_left > 0) begin
			voltage_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (volts_to_send.size() > 0) begin
			voltage_mv <= volts_to_send.pop_front();
			voltage_valid <= 1'b1;
			sent_cnt <= sent_cnt + 1;
			if (idle_on && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 18);
		end else begin
			voltage_valid <= 1'b0;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			result_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			result_stall <= 1'b1;
			hold_left <= $urandom_range(0, 17);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : scoreboard
		sleep_plan_t want;
		logic        took_in;
		logic        took_out;
		took_in = arst_n && voltage_valid && !voltage_stall;
		took_out = arst_n && result_valid && !result_stall;
		if (took_in) begin
			awaited_plans.push_back(plan_wake(voltage_mv));
			taken_cnt++;
		end
		if (took_out) begin
			if (awaited_plans.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word sleep_seconds=%0d suspended=%0b band=%0d",
					$time, sleep_seconds, suspended, band);
			end else begin
				want = awaited_plans.pop_front();
				if (sleep_seconds !== want.secs) begin
					mismatches++;
					$display("%0t: sleep_seconds expected %0d got %0d",
						$time, want.secs, sleep_seconds);
				end
				if (suspended !== want.susp) begin
					mismatches++;
					$display("%0t: suspended expected %0b got %0b",
						$time, want.susp, suspended);
				end
				if (band !== want.bnd) begin
					mismatches++;
					$display("%0t: band expected %0d got %0d", $time, want.bnd, band);
				end
			end
		end
		if (took_in || took_out) quiet_cycles = 0;
		else quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("energy_aware_sleep_scheduler_tb: errors");
		$finish;
	end

	task automatic send(word_t v);
		volts_to_send.push_back(v);
		pushed_cnt++;
		gen_last_mv = v;
	endtask

	task automatic drain();
		while (taken_cnt != pushed_cnt || awaited_plans.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, word_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS) reg_copy[idx] = val;
	endtask

	initial begin
		word_t opening_mv [];
		int sh;
		int tg;
		int cl;
		int fast;
		int mv;
		opening_mv = '{16'd0, 16'd3000, 16'd3001, 16'd4500, 16'd4501, 16'd4505,
			16'd4600, 16'd4590, 16'd4999, 16'd5000, 16'd65535, 16'd4000, 16'd4000,
			16'd4001, 16'd4499, 16'd4502, 16'd4510, 16'd3500, 16'd3499, 16'd4500,
			16'd65535, 16'd0};
		reg_copy[REG_FASTEST] = RST_FASTEST;
		reg_copy[REG_SLOWEST] = RST_SLOWEST;
		reg_copy[REG_LOWV]    = RST_LOWV;
		reg_copy[REG_SHUTOFF] = RST_SHUTOFF;
		reg_copy[REG_CEILING] = RST_CEILING;
		reg_copy[REG_TARGET]  = RST_TARGET;
		period_now = RST_PERIOD;
		last_mv = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_mv[i]) send(opening_mv[i]);
		drain();

		for (int ph = 1; ph <= SETTING_PHASES; ph++) begin
			case (ph)
				1: begin
					// widest limits; big periods overflow 16 bits before the clamp
					write_reg(REG_FASTEST, 16'd1);
					write_reg(REG_SLOWEST, 16'hFFFF);
					write_reg(REG_LOWV, 16'hFFFF);
					write_reg(REG_SHUTOFF, 16'd0);
					write_reg(REG_CEILING, 16'hFFFF);
					write_reg(REG_TARGET, 16'h8000);
					write_reg(REG_SPARE_6, 16'h1234);
					write_reg(REG_SPARE_7, 16'hFFFF);
					send(16'd0);
					send(16'd40000);
					send(16'd20000);
					send(16'd65535);
					send(16'd1);
					send(16'd32768);
					send(16'd32769);
				end
				2: begin
					// fastest above slowest: slowest wins
					write_reg(REG_FASTEST, 16'hFFFF);
					write_reg(REG_SLOWEST, 16'd1);
					write_reg(REG_LOWV, 16'd7200);
					write_reg(REG_SHUTOFF, 16'd3000);
					write_reg(REG_CEILING, 16'd5000);
					write_reg(REG_TARGET, 16'd4500);
					long_hold_req = 1'b1;
					send(16'd4600);
					send(16'd4000);
					send(16'd5500);
				end
				3: begin
					// zero period: shrink saturates at zero
					write_reg(REG_FASTEST, 16'd0);
					write_reg(REG_SLOWEST, 16'd20);
					write_reg(REG_LOWV, 16'd0);
					write_reg(REG_SHUTOFF, 16'd100);
					write_reg(REG_CEILING, 16'd60000);
					write_reg(REG_TARGET, 16'd30000);
					send(16'd50);
					send(16'd200);
					send(16'd150);
					send(16'd50);
					send(16'd40000);
					send(16'd100);
				end
				4: begin
					// thresholds out of order
					write_reg(REG_FASTEST, 16'd1);
					write_reg(REG_SLOWEST, 16'd7200);
					write_reg(REG_SHUTOFF, 16'd50000);
					write_reg(REG_CEILING, 16'd10000);
					write_reg(REG_TARGET, 16'd20000);
				end
				default: begin
					sh = $urandom_range(0, 30000);
					tg = sh + $urandom_range(1, 15000);
					cl = tg + $urandom_range(1, 15000);
					if ($urandom_range(0, 3) == 0) begin
						sh = $urandom_range(0, 65535);
						tg = $urandom_range(0, 65535);
						cl = $urandom_range(0, 65535);
					end
					fast = $urandom_range(1, 300);
					write_reg(REG_FASTEST, word_t'(fast));
					write_reg(REG_SLOWEST, ($urandom_range(0, 3) == 0) ? 16'hFFFF :
						word_t'($urandom_range(fast, 20000)));
					write_reg(REG_LOWV, word_t'($urandom_range(1, 65535)));
					write_reg(REG_SHUTOFF, word_t'(sh));
					write_reg(REG_CEILING, word_t'(cl));
					write_reg(REG_TARGET, word_t'(tg));
				end
			endcase
			idle_on = (ph < SETTING_PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				case ($urandom_range(0, 9))
					0, 1: mv = int'(reg_copy[REG_SHUTOFF]) + $urandom_range(0, 40) - 20;
					2, 3: mv = int'(reg_copy[REG_TARGET]) + $urandom_range(0, 40) - 20;
					4:    mv = int'(reg_copy[REG_CEILING]) + $urandom_range(0, 40) - 20;
					5, 6, 7: mv = int'(gen_last_mv) + $urandom_range(0, 30) - 15;
					8:    mv = int'(gen_last_mv);
					default: mv = $urandom_range(0, 65535);
				endcase
				send(word_t'(mv));
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_plans.size() == 0) begin
			$display("energy_aware_sleep_scheduler_tb: clean");
		end else begin
			$display("energy_aware_sleep_scheduler_tb: errors");
		end
		$finish;
	end

endmodule
